// ----- src/d4_pkg.sv -----
// Shared types and constants for the two-dimensional D4 wavelet block.
// Holds the channel beat structs, command and register codes and the tap control struct.
// Depends on nothing; every other file of the block imports it.
package d4_pkg;

  localparam int OUT_W = 24;
  localparam int FIELD_W = 6;
  localparam int IN_SAMPLE_W = 16;
  localparam int COEF_W = 16;
  localparam int LOG2_W = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_XFORM = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  localparam logic KIND_DONE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_COEF_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_LOG2 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_LOG2 = 3'd5;

  typedef struct packed {
    logic [1:0] command;
    logic [FIELD_W-1:0] row;
    logic [FIELD_W-1:0] col;
    logic signed [IN_SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] value;
    logic kind;
  } out_item_t;

  typedef logic [3:0][COEF_W-1:0] coef_set_t;

  typedef struct packed {
    logic valid;
    logic [1:0] tap;
  } tap_ctrl_t;

endpackage

// ----- src/d4_mac.sv -----
// Shared multiply, round and accumulate unit for the low-pass and high-pass filters.
// Uses d4_pkg for the tap control struct, the coefficient set and the output width.
module d4_mac import d4_pkg::*; #(
  parameter int ROW_W = 20,
  parameter int FRAC = 14
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  tap_ctrl_t               ctrl_i,
  input  logic signed [ROW_W-1:0] data_i,
  input  coef_set_t               coefs_i,
  output logic signed [ROW_W-1:0] row_lo_o,
  output logic signed [ROW_W-1:0] row_hi_o,
  output logic signed [OUT_W-1:0] out_lo_o,
  output logic signed [OUT_W-1:0] out_hi_o
);

  localparam int PW = ROW_W + 17;
  localparam int RW = PW + 1 - FRAC;
  localparam int AW = RW + 2;
  localparam logic signed [PW:0] HALF = (PW+1)'(1) <<< (FRAC - 1);

  logic signed [16:0] h_k;
  logic signed [16:0] g_k;
  logic signed [PW-1:0] d_ext;
  logic signed [PW-1:0] prod_h_r;
  logic signed [PW-1:0] prod_g_r;
  tap_ctrl_t s1_r;
  logic signed [PW:0] sum_h;
  logic signed [PW:0] sum_g;
  logic signed [RW-1:0] rnd_h;
  logic signed [RW-1:0] rnd_g;
  logic signed [AW-1:0] acc_h_r;
  logic signed [AW-1:0] acc_g_r;
  logic signed [AW-1:0] acc_h_nxt;
  logic signed [AW-1:0] acc_g_nxt;
  logic [AW-ROW_W:0] top_h;
  logic [AW-ROW_W:0] top_g;

  // High-pass taps are the low-pass taps reversed with alternating sign.
  always_comb begin
    h_k = 17'(signed'(coefs_i[ctrl_i.tap]));
    case (ctrl_i.tap)
      2'd0: g_k = 17'(signed'(coefs_i[3]));
      2'd1: g_k = -17'(signed'(coefs_i[2]));
      2'd2: g_k = 17'(signed'(coefs_i[1]));
      2'd3: g_k = -17'(signed'(coefs_i[0]));
      default: g_k = '0;
    endcase
  end

  assign d_ext = PW'(data_i);

  always_ff @(posedge clk) begin
    prod_h_r <= d_ext * PW'(h_k);
    prod_g_r <= d_ext * PW'(g_k);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
    end else begin
      s1_r <= ctrl_i;
    end
  end

  // Round half up: add one half and keep the floor of the shifted sum.
  assign sum_h = (PW+1)'(prod_h_r) + HALF;
  assign sum_g = (PW+1)'(prod_g_r) + HALF;
  assign rnd_h = sum_h[PW:FRAC];
  assign rnd_g = sum_g[PW:FRAC];

  always_comb begin
    acc_h_nxt = acc_h_r;
    acc_g_nxt = acc_g_r;
    if (s1_r.valid) begin
      if (s1_r.tap == 2'd0) begin
        acc_h_nxt = AW'(rnd_h);
        acc_g_nxt = AW'(rnd_g);
      end else begin
        acc_h_nxt = acc_h_r + AW'(rnd_h);
        acc_g_nxt = acc_g_r + AW'(rnd_g);
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_h_r <= acc_h_nxt;
    acc_g_r <= acc_g_nxt;
  end

  assign top_h = acc_h_r[AW-1:ROW_W-1];
  assign top_g = acc_g_r[AW-1:ROW_W-1];

  always_comb begin
    if ((&top_h) || !(|top_h)) begin
      row_lo_o = acc_h_r[ROW_W-1:0];
    end else begin
      row_lo_o = acc_h_r[AW-1] ? {1'b1, {(ROW_W-1){1'b0}}} : {1'b0, {(ROW_W-1){1'b1}}};
    end
    if ((&top_g) || !(|top_g)) begin
      row_hi_o = acc_g_r[ROW_W-1:0];
    end else begin
      row_hi_o = acc_g_r[AW-1] ? {1'b1, {(ROW_W-1){1'b0}}} : {1'b0, {(ROW_W-1){1'b1}}};
    end
  end

  generate
    if (AW > OUT_W) begin : g_out_sat
      logic [AW-OUT_W:0] otop_h;
      logic [AW-OUT_W:0] otop_g;
      assign otop_h = acc_h_r[AW-1:OUT_W-1];
      assign otop_g = acc_g_r[AW-1:OUT_W-1];
      always_comb begin
        if ((&otop_h) || !(|otop_h)) begin
          out_lo_o = acc_h_r[OUT_W-1:0];
        end else begin
          out_lo_o = acc_h_r[AW-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
        end
        if ((&otop_g) || !(|otop_g)) begin
          out_hi_o = acc_g_r[OUT_W-1:0];
        end else begin
          out_hi_o = acc_g_r[AW-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
        end
      end
    end else begin : g_out_ext
      assign out_lo_o = OUT_W'(acc_h_r);
      assign out_hi_o = OUT_W'(acc_g_r);
    end
  endgenerate

endmodule

// ----- src/daubechies_d4_2d_transform.sv -----
// Single-level 2D D4 wavelet transform over three on-chip sample memories.
// Load and read beats are taken one per cycle while idle and no read result is held up.
// A read answers via the memory read register, then the result register. Each output pair
// costs eight steps of the shared d4_mac unit (four memory reads, pipeline drain, two writes) over two passes.
// Synchronous active-low reset clears control state and restores the default taps and size.
// The memories are not cleared. Depends on d4_pkg and d4_mac.
module daubechies_d4_2d_transform import d4_pkg::*; #(
  parameter int MAX_DIM = 64,
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Widths that follow from the parameters. MAX_DIM is a power of two.
  localparam int IDX_W = $clog2(MAX_DIM);
  localparam int ADDR_W = 2 * IDX_W;
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int ROW_W = SAMPLE_BITS + 4;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [2:0] STEP_LAST_RD = 3'd3;
  localparam logic [2:0] STEP_WR_LO = 3'd6;
  localparam logic [2:0] STEP_WR_HI = 3'd7;

  // Configuration registers. The port never pushes back.
  coef_set_t coef_r;
  logic [LOG2_W-1:0] rows_log2_r;
  logic [LOG2_W-1:0] cols_log2_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r[0] <= 16'sd7913;
      coef_r[1] <= 16'sd13706;
      coef_r[2] <= 16'sd3672;
      coef_r[3] <= -16'sd2120;
      rows_log2_r <= 3'd6;
      cols_log2_r <= 3'd6;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_COEF_0: coef_r[0] <= cfg_data;
        CFG_COEF_1: coef_r[1] <= cfg_data;
        CFG_COEF_2: coef_r[2] <= cfg_data;
        CFG_COEF_3: coef_r[3] <= cfg_data;
        CFG_ROWS_LOG2: rows_log2_r <= cfg_data[LOG2_W-1:0];
        CFG_COLS_LOG2: cols_log2_r <= cfg_data[LOG2_W-1:0];
        default: ;
      endcase
    end
  end

  // The size in use is clamped between 2 and MAX_DIM on each axis.
  logic [3:0] rows_l;
  logic [3:0] cols_l;
  logic [IDX_W:0] rows_n;
  logic [IDX_W:0] cols_n;
  logic [IDX_W-1:0] rows_mask;
  logic [IDX_W-1:0] cols_mask;

  always_comb begin
    rows_l = 4'(rows_log2_r);
    cols_l = 4'(cols_log2_r);
    if (rows_l < 4'd1) rows_l = 4'd1;
    if (rows_l > 4'(IDX_W)) rows_l = 4'(IDX_W);
    if (cols_l < 4'd1) cols_l = 4'd1;
    if (cols_l > 4'(IDX_W)) cols_l = 4'(IDX_W);
    rows_n = (IDX_W+1)'(1) << rows_l;
    cols_n = (IDX_W+1)'(1) << cols_l;
    rows_mask = rows_n[IDX_W-1:0] - 1'b1;
    cols_mask = cols_n[IDX_W-1:0] - 1'b1;
  end

  // Handshake bookkeeping. pend_r marks read data from the output memory
  // that still has to move into the result register.
  logic [1:0] state_r, state_nxt;
  logic pend_r, pend_nxt;
  logic out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;
  logic out_free;
  logic in_acc;
  logic acc_load;
  logic acc_xform;
  logic acc_read;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || (pend_r && !out_free);
  assign in_acc = in_valid && !in_stall;
  assign acc_load = in_acc && (in_data.command == CMD_LOAD);
  assign acc_xform = in_acc && (in_data.command == CMD_XFORM);
  assign acc_read = in_acc && (in_data.command == CMD_READ);

  // Command addresses are taken modulo MAX_DIM.
  logic [7:0] cmd_row8;
  logic [7:0] cmd_col8;
  logic [ADDR_W-1:0] cmd_addr;
  logic [23:0] sample24;

  assign cmd_row8 = {2'b00, in_data.row};
  assign cmd_col8 = {2'b00, in_data.col};
  assign cmd_addr = {cmd_row8[IDX_W-1:0], cmd_col8[IDX_W-1:0]};
  // Only the low SAMPLE_BITS of the field are kept, read back as signed.
  assign sample24 = {8'b0, in_data.sample};

  // Transform sequencer: pass 0 runs along rows, pass 1 along columns.
  // For each output pair the four taps are read in steps 0 to 3, the
  // product pipeline drains in steps 4 and 5, and the low-pass and
  // high-pass results are written in steps 6 and 7.
  logic pass_r, pass_nxt;
  logic [2:0] step_r, step_nxt;
  logic [IDX_W-1:0] outer_r, outer_nxt;
  logic [IDX_W-1:0] inner_r, inner_nxt;
  logic [IDX_W-1:0] pos_mask;
  logic [IDX_W-1:0] half_n;
  logic [IDX_W-1:0] outer_last;
  logic [IDX_W-1:0] tap_pos;
  logic [IDX_W-1:0] wr_pos;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic issue;
  logic do_write;
  tap_ctrl_t rd_ctrl_r;

  always_comb begin
    pos_mask = pass_r ? rows_mask : cols_mask;
    half_n = pass_r ? rows_n[IDX_W:1] : cols_n[IDX_W:1];
    outer_last = pass_r ? cols_mask : rows_mask;
    tap_pos = IDX_W'(({1'b0, inner_r} << 1) + (IDX_W+1)'(step_r[1:0])) & pos_mask;
    wr_pos = (step_r == STEP_WR_HI) ? inner_r + half_n : inner_r;
    rd_addr = pass_r ? {tap_pos, outer_r} : {outer_r, tap_pos};
    wr_addr = pass_r ? {wr_pos, outer_r} : {outer_r, wr_pos};
    issue = (state_r == ST_RUN) && (step_r <= STEP_LAST_RD);
    do_write = (state_r == ST_RUN) && (step_r >= STEP_WR_LO);
  end

  always_comb begin
    state_nxt = state_r;
    pass_nxt = pass_r;
    step_nxt = step_r;
    outer_nxt = outer_r;
    inner_nxt = inner_r;
    case (state_r)
      ST_IDLE: begin
        if (acc_xform) begin
          state_nxt = ST_RUN;
          pass_nxt = 1'b0;
          step_nxt = '0;
          outer_nxt = '0;
          inner_nxt = '0;
        end
      end
      ST_RUN: begin
        step_nxt = step_r + 3'd1;
        if (step_r == STEP_WR_HI) begin
          if (inner_r != half_n - 1'b1) begin
            inner_nxt = inner_r + 1'b1;
          end else begin
            inner_nxt = '0;
            if (outer_r != outer_last) begin
              outer_nxt = outer_r + 1'b1;
            end else begin
              outer_nxt = '0;
              if (!pass_r) begin
                pass_nxt = 1'b1;
              end else begin
                state_nxt = ST_DONE;
              end
            end
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Result register. Read data has priority; the done beat waits its turn.
  logic signed [OUT_W-1:0] out_rdata;

  always_comb begin
    pend_nxt = acc_read || (pend_r && !out_free);
    out_valid_nxt = out_valid_r;
    out_data_nxt = out_data_r;
    if (pend_r && out_free) begin
      out_valid_nxt = 1'b1;
      out_data_nxt.value = out_rdata;
      out_data_nxt.kind = KIND_READ;
    end else if ((state_r == ST_DONE) && out_free) begin
      out_valid_nxt = 1'b1;
      out_data_nxt.value = '0;
      out_data_nxt.kind = KIND_DONE;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pass_r <= 1'b0;
      step_r <= '0;
      outer_r <= '0;
      inner_r <= '0;
      pend_r <= 1'b0;
      out_valid_r <= 1'b0;
      rd_ctrl_r <= '0;
    end else begin
      state_r <= state_nxt;
      pass_r <= pass_nxt;
      step_r <= step_nxt;
      outer_r <= outer_nxt;
      inner_r <= inner_nxt;
      pend_r <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      rd_ctrl_r.valid <= issue;
      rd_ctrl_r.tap <= step_r[1:0];
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  // Sample memory: written by loads, read by the row pass.
  logic [SAMPLE_BITS-1:0] in_mem [DEPTH];
  logic [SAMPLE_BITS-1:0] in_rdata;

  always_ff @(posedge clk) begin
    if (acc_load) begin
      in_mem[cmd_addr] <= sample24[SAMPLE_BITS-1:0];
    end
    if (issue && !pass_r) begin
      in_rdata <= in_mem[rd_addr];
    end
  end

  // Intermediate memory: written by the row pass, read by the column pass.
  logic [ROW_W-1:0] mid_mem [DEPTH];
  logic [ROW_W-1:0] mid_rdata;
  logic signed [ROW_W-1:0] row_lo;
  logic signed [ROW_W-1:0] row_hi;

  always_ff @(posedge clk) begin
    if (do_write && !pass_r) begin
      mid_mem[wr_addr] <= (step_r == STEP_WR_HI) ? row_hi : row_lo;
    end
    if (issue && pass_r) begin
      mid_rdata <= mid_mem[rd_addr];
    end
  end

  // Coefficient memory: written by the column pass, read by read commands.
  logic [OUT_W-1:0] out_mem [DEPTH];
  logic signed [OUT_W-1:0] out_lo;
  logic signed [OUT_W-1:0] out_hi;

  always_ff @(posedge clk) begin
    if (do_write && pass_r) begin
      out_mem[wr_addr] <= (step_r == STEP_WR_HI) ? out_hi : out_lo;
    end
    if (acc_read) begin
      out_rdata <= out_mem[cmd_addr];
    end
  end

  // Filter datapath, fed with the tap that the memories return this cycle.
  logic signed [ROW_W-1:0] mac_data;

  assign mac_data = pass_r ? signed'(mid_rdata) : ROW_W'(signed'(in_rdata));

  d4_mac #(
    .ROW_W (ROW_W),
    .FRAC  (COEF_FRAC_BITS)
  ) u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl_i   (rd_ctrl_r),
    .data_i   (mac_data),
    .coefs_i  (coef_r),
    .row_lo_o (row_lo),
    .row_hi_o (row_hi),
    .out_lo_o (out_lo),
    .out_hi_o (out_hi)
  );

  // A transform starts on the row pass from the first pair.
  a_xform_start: assert property (@(posedge clk) disable iff (!rst_n)
    acc_xform |=> (state_r == ST_RUN) && !pass_r && (step_r == 3'd0))
    else $error("transform did not start on the row pass");

  // Pending read data is always drained before a transform can run.
  a_no_pend_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> !pend_r)
    else $error("read data pending during transform");

  // No tap may reach the accumulator while a finished pair is written out.
  a_drain_before_write: assert property (@(posedge clk) disable iff (!rst_n)
    do_write |-> !rd_ctrl_r.valid)
    else $error("tap in flight during result write");

  // Finishing a transform produces the done beat with a zero value.
  a_done_beat: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DONE) && out_free) |=>
      (out_valid_r && (out_data_r.kind == KIND_DONE) && (out_data_r.value == '0)))
    else $error("done beat missing or malformed");

endmodule

// ----- tb/d4_checker.sv -----
`timescale 1ns / 100ps
// Checker for the 2D D4 wavelet block: watches the input, result and register channels.
// Keeps its own copy of taps, sizes and the three stores, predicts every result beat
// and compares it with what the block returns. Depends on d4_pkg only.
module d4_checker import d4_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_item_t             out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    pending,
  output int                    errors
);

  localparam int DIM = 64;
  localparam int FRAC = 14;
  localparam int ROW_W = 20;

  logic signed [COEF_W-1:0] taps_lo [4];
  logic [LOG2_W-1:0] rows_lg, cols_lg;
  longint samples [DIM*DIM];
  longint row_sums [DIM*DIM];
  longint coefs_out [DIM*DIM];
  out_item_t expected_beats [$];

  assign pending = expected_beats.size();

  function automatic longint mul_round(longint x, longint c);
    return (x * c + (longint'(1) << (FRAC - 1))) >>> FRAC;
  endfunction

  function automatic longint clip(longint v, int bits);
    longint hi;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
  endfunction

  function automatic int clamp_log2(logic [LOG2_W-1:0] v);
    return v < 1 ? 1 : (v > 6 ? 6 : int'(v));
  endfunction

  function automatic longint four_taps(longint k [4], longint a, longint b, longint x,
                                       longint y);
    return mul_round(a, k[0]) + mul_round(b, k[1]) + mul_round(x, k[2]) + mul_round(y, k[3]);
  endfunction

  // Row pass into the row store, then column pass into the coefficient store.
  task automatic run_wavelet();
    longint h [4];
    longint g [4];
    longint a, b, x, y;
    int nr, nc;
    nr = 1 << clamp_log2(rows_lg);
    nc = 1 << clamp_log2(cols_lg);
    for (int i = 0; i < 4; i++) h[i] = longint'(taps_lo[i]);
    g[0] = h[3]; g[1] = -h[2]; g[2] = h[1]; g[3] = -h[0];
    for (int r = 0; r < nr; r++) begin
      for (int i = 0; i < nc / 2; i++) begin
        a = samples[r*DIM + 2*i];
        b = samples[r*DIM + 2*i + 1];
        x = samples[r*DIM + (2*i + 2) % nc];
        y = samples[r*DIM + (2*i + 3) % nc];
        row_sums[r*DIM + i] = clip(four_taps(h, a, b, x, y), ROW_W);
        row_sums[r*DIM + i + nc/2] = clip(four_taps(g, a, b, x, y), ROW_W);
      end
    end
    for (int c = 0; c < nc; c++) begin
      for (int i = 0; i < nr / 2; i++) begin
        a = row_sums[(2*i)*DIM + c];
        b = row_sums[(2*i + 1)*DIM + c];
        x = row_sums[((2*i + 2) % nr)*DIM + c];
        y = row_sums[((2*i + 3) % nr)*DIM + c];
        coefs_out[i*DIM + c] = clip(four_taps(h, a, b, x, y), OUT_W);
        coefs_out[(i + nr/2)*DIM + c] = clip(four_taps(g, a, b, x, y), OUT_W);
      end
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    int addr;
    if (!rst_n) begin
      taps_lo[0] = 16'sd7913;
      taps_lo[1] = 16'sd13706;
      taps_lo[2] = 16'sd3672;
      taps_lo[3] = -16'sd2120;
      rows_lg = 3'd6;
      cols_lg = 3'd6;
      errors = 0;
      expected_beats.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_COEF_0, CFG_COEF_1, CFG_COEF_2, CFG_COEF_3: taps_lo[cfg_index[1:0]] = cfg_data;
          CFG_ROWS_LOG2: rows_lg = cfg_data[LOG2_W-1:0];
          CFG_COLS_LOG2: cols_lg = cfg_data[LOG2_W-1:0];
          default: ;
        endcase
      end
      // Result beat is compared before the same edge's input beat can add a new one.
      if (out_valid && !out_stall) begin
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected result beat value=%0d kind=%0d", $time,
                   out_data.value, out_data.kind);
          errors++;
        end else begin
          want = expected_beats.pop_front();
          if (out_data.kind !== want.kind) begin
            $display("%0t: kind mismatch expected %0d actual %0d", $time, want.kind,
                     out_data.kind);
            errors++;
          end
          if (out_data.value !== want.value) begin
            $display("%0t: value mismatch expected %0d actual %0d", $time, want.value,
                     out_data.value);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        addr = int'(in_data.row) * DIM + int'(in_data.col);
        case (in_data.command)
          CMD_LOAD: samples[addr] = longint'(in_data.sample);
          CMD_XFORM: begin
            run_wavelet();
            want.value = '0;
            want.kind = KIND_DONE;
            expected_beats.push_back(want);
          end
          CMD_READ: begin
            want.value = coefs_out[addr][OUT_W-1:0];
            want.kind = KIND_READ;
            expected_beats.push_back(want);
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Top of the testbench for the 2D D4 wavelet block: clock, reset, stimulus and verdict.
// Depends on d4_pkg, the block itself and d4_checker, which does all the checking.
module tb_top import d4_pkg::*; ();

  // Command code the block has no use for; it must be swallowed without a result.
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int TIMEOUT_CYCLES = 1500000;
  localparam int HOLD_CYCLES = 300;

  logic clk;
  logic rst_n;
  logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
  in_item_t in_data;
  out_item_t out_data;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int pending, errors;

  // Idle rates in percent, set per phase by the stimulus process.
  int send_idle_pct, recv_idle_pct;
  // Each bump of the ticket asks the stall process for one long hold-off.
  int hold_ticket, hold_seen, hold_left;
  int cycles = 0;

  daubechies_d4_2d_transform u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  d4_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pending(pending), .errors(errors)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result side: random stalls at the phase's rate, or a long hold-off when asked.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_seen <= 0;
      hold_left <= 0;
    end else if (hold_seen != hold_ticket) begin
      hold_seen <= hold_ticket;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > TIMEOUT_CYCLES) begin
      $display("[daubechies_d4_2d_transform] ERROR");
      $finish;
    end
  end

  // One input beat. An idle gap, if any, drops valid and waits on the clock before the new beat
  // goes up, so valid is never lowered and raised in one step.
  task automatic send_beat(logic [1:0] cmd, int r, int c, logic [15:0] smp);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.command <= cmd;
    in_data.row <= r[FIELD_W-1:0];
    in_data.col <= c[FIELD_W-1:0];
    in_data.sample <= smp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    in_valid <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Waits until every predicted result has come back, then lets trailing loads settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Samples lean toward the rails so that both saturation points get exercised.
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(7))
      0: return 16'h7fff;
      1: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_tap();
    case ($urandom_range(5))
      0: return 16'h7fff;
      1: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly small matrices; now and then a full-width dimension.
  function automatic int pick_log2();
    return ($urandom_range(9) == 0) ? 6 : $urandom_range(3, 1);
  endfunction

  // A well-formed sequence: fill the active area, transform, read coefficients back,
  // with a little noise (spare command, stray loads, reads outside the area) mixed in.
  task automatic wavelet_round(int rl, int cl, int n_reads);
    int nr, nc;
    nr = 1 << rl;
    nc = 1 << cl;
    for (int r = 0; r < nr; r++)
      for (int c = 0; c < nc; c++) begin
        send_beat(CMD_LOAD, r, c, pick_sample());
        if ($urandom_range(49) == 0) send_beat(CMD_SPARE, $urandom_range(63),
                                                $urandom_range(63), 16'($urandom));
      end
    send_beat(CMD_XFORM, $urandom_range(63), $urandom_range(63), 16'($urandom));
    for (int k = 0; k < n_reads; k++) begin
      // Rows 0 and 1 hold coefficients in every column since the opening transform,
      // so reads may also go there; stray loads may go anywhere.
      case ($urandom_range(9))
        0: send_beat(CMD_READ, $urandom_range(1), $urandom_range(63), 16'($urandom));
        1: send_beat(CMD_LOAD, $urandom_range(63), $urandom_range(63), pick_sample());
        default: send_beat(CMD_READ, $urandom_range(nr - 1), $urandom_range(nc - 1),
                           16'($urandom));
      endcase
    end
  endtask

  task automatic set_shape(logic [15:0] rl, logic [15:0] cl);
    write_reg(CFG_ROWS_LOG2, rl);
    write_reg(CFG_COLS_LOG2, cl);
  endtask

  initial begin
    int rl, cl, sent;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_ticket = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Opening fill at the reset taps: two full-width rows are loaded and transformed,
    // which writes rows 0 and 1 of the coefficients in every column.
    set_shape(16'd1, 16'd6);
    for (int r = 0; r < 2; r++)
      for (int c = 0; c < 64; c++) send_beat(CMD_LOAD, r, c, pick_sample());
    send_beat(CMD_XFORM, 0, 0, 16'h0);

    // Directed: corner reads, the spare command, rail samples, all-ones fields.
    send_beat(CMD_READ, 0, 0, 16'h0);
    send_beat(CMD_READ, 1, 63, 16'hffff);
    send_beat(CMD_READ, 0, 63, 16'h0);
    send_beat(CMD_READ, 1, 0, 16'h0);
    send_beat(CMD_SPARE, 63, 63, 16'hffff);
    send_beat(CMD_SPARE, 0, 0, 16'h0);
    send_beat(CMD_LOAD, 0, 0, 16'h7fff);
    send_beat(CMD_LOAD, 0, 1, 16'h8000);
    send_beat(CMD_LOAD, 1, 0, 16'h8000);
    send_beat(CMD_LOAD, 1, 1, 16'h7fff);
    send_beat(CMD_LOAD, 63, 63, 16'h8000);
    drain();

    // Rail taps on the smallest matrix: sums run into both saturation limits.
    write_reg(CFG_COEF_0, 16'h7fff);
    write_reg(CFG_COEF_1, 16'h8000);
    write_reg(CFG_COEF_2, 16'h7fff);
    write_reg(CFG_COEF_3, 16'h8000);
    set_shape(16'd1, 16'd1);
    send_beat(CMD_XFORM, 0, 0, 16'h0);
    for (int r = 0; r < 2; r++)
      for (int c = 0; c < 2; c++) send_beat(CMD_READ, r, c, 16'h0);
    drain();

    // Out-of-range size codes clamp to the legal range: zero acts as one, seven as six.
    set_shape(16'd0, 16'd7);
    send_beat(CMD_XFORM, 0, 0, 16'h0);
    send_beat(CMD_READ, 1, 63, 16'h0);
    send_beat(CMD_READ, 0, 32, 16'h0);
    drain();

    // Three idling phases, each a run of random rounds with fresh taps and shapes.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 64 : 0;
      recv_idle_pct = (ph == 0) ? 64 : (ph == 1) ? 12 : 0;
      sent = 0;
      while (sent < 200) begin
        write_reg(CFG_COEF_0, pick_tap());
        write_reg(CFG_COEF_1, pick_tap());
        write_reg(CFG_COEF_2, pick_tap());
        write_reg(CFG_COEF_3, pick_tap());
        rl = pick_log2();
        cl = ($urandom_range(3) == 0) ? 1 : pick_log2();
        if (rl + cl > 8) rl = 1;
        set_shape(16'(rl), 16'(cl));
        wavelet_round(rl, cl, $urandom_range(30, 8));
        sent += (1 << (rl + cl)) + 20;
        // The sender pauses here until every predicted result has arrived.
        drain();
      end
      // Long hold-off on the result side while reads keep coming, so the block backs up.
      if (ph == 0) begin
        hold_ticket = hold_ticket + 1;
        for (int k = 0; k < 40; k++)
          send_beat(CMD_READ, $urandom_range(1), $urandom_range(63), 16'($urandom));
        drain();
      end
    end

    // Restore the reset taps and a full-width row shape before the end.
    write_reg(CFG_COEF_0, 16'd7913);
    write_reg(CFG_COEF_1, 16'd13706);
    write_reg(CFG_COEF_2, 16'd3672);
    write_reg(CFG_COEF_3, 16'hf7b8);
    set_shape(16'd1, 16'd6);
    wavelet_round(1, 6, 16);
    drain();

    if (errors == 0) begin
      $display("[daubechies_d4_2d_transform] OK");
    end else begin
      $display("[daubechies_d4_2d_transform] ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/d4_pkg.sv
src/d4_mac.sv
src/daubechies_d4_2d_transform.sv
tb/d4_checker.sv
tb/tb_top.sv
